// File: sv/fbf_pkg.sv
// Shared types and constants for the framed byte FIFO.
// Used by the controller, datapath, top level and checker; depends on nothing else.
package fbf_pkg;

    // Default ring depths, handed to the top-level parameters.
    localparam int DATA_DEPTH_DEF  = 256;
    localparam int FRAME_DEPTH_DEF = 16;

    // Field widths of the request and result payloads.
    localparam int FUNC_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int LEN_FLD_W  = 9;
    localparam int WAIT_FLD_W = 5;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRAMED = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_RAW    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP         = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_OPEN        = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REOPEN      = 3'd4;

    // One request as it enters the block.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] data_byte;
    } req_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic [BYTE_W-1:0]     read_byte;
        logic [LEN_FLD_W-1:0]  frame_length;
        logic [LEN_FLD_W-1:0]  bytes_left;
        logic [WAIT_FLD_W-1:0] frames_waiting;
        logic                  fault;
    } result_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // capture the request for an operation that waits for a store read
        logic commit;       // update state and register the result
        logic use_latched;  // execute the captured request, not the live one
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_read;   // the live request must wait for a store read
    } stat_t;

endpackage

// File: sv/fbf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; used for the byte store and the length store.
module fbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/fbf_ctrl.sv
// Controller state machine for the framed byte FIFO.
// Depends on fbf_pkg for the state, command and status types.
module fbf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  fbf_pkg::stat_t stat,
    output fbf_pkg::cmd_t  cmd,
    output logic           busy
);

    fbf_pkg::state_t state_reg;
    fbf_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a request that reads a store goes to the wait state for the data.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbf_pkg::ST_IDLE:
            begin
                if (start && stat.needs_read)
                begin
                    state_next = fbf_pkg::ST_WAIT;
                end
            end
            fbf_pkg::ST_WAIT:
            begin
                state_next = fbf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fbf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: commands to the datapath and the busy flag.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        case (state_reg)
            fbf_pkg::ST_IDLE:
            begin
                cmd.latch  = start && stat.needs_read;
                cmd.commit = start && !stat.needs_read;
            end
            fbf_pkg::ST_WAIT:
            begin
                cmd.commit      = 1'b1;
                cmd.use_latched = 1'b1;
                busy            = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/fbf_datapath.sv
// Datapath of the framed byte FIFO: pointers, counters, both stores, result register.
// Depends on fbf_pkg and fbf_ram.
module fbf_datapath #(
    parameter int DATA_DEPTH  = fbf_pkg::DATA_DEPTH_DEF,
    parameter int FRAME_DEPTH = fbf_pkg::FRAME_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fbf_pkg::BYTE_W-1:0]  cfg_wdata,
    input  fbf_pkg::req_t               req,
    input  fbf_pkg::cmd_t               cmd,
    output fbf_pkg::stat_t              stat,
    output logic                        done,
    output fbf_pkg::result_t            result
);

    localparam int BA_W  = $clog2(DATA_DEPTH);
    localparam int FA_W  = $clog2(FRAME_DEPTH);
    localparam int CNT_W = $clog2(DATA_DEPTH + 1);
    localparam int FC_W  = $clog2(FRAME_DEPTH + 1);
    localparam int LEN_EXT_W  = (CNT_W > fbf_pkg::LEN_FLD_W) ? CNT_W : fbf_pkg::LEN_FLD_W;
    localparam int WAIT_EXT_W = (FC_W > fbf_pkg::WAIT_FLD_W) ? FC_W : fbf_pkg::WAIT_FLD_W;

    // Architectural state.
    logic [fbf_pkg::BYTE_W-1:0] marker_reg;
    logic [BA_W-1:0]  bwp_reg, bwp_next;
    logic [BA_W-1:0]  brp_reg, brp_next;
    logic [CNT_W-1:0] ofc_reg, ofc_next;
    logic [FA_W-1:0]  lwp_reg, lwp_next;
    logic [FA_W-1:0]  lrp_reg, lrp_next;
    logic [FC_W-1:0]  closed_reg, closed_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [BA_W-1:0]  saved_rp_reg, saved_rp_next;
    logic [CNT_W-1:0] saved_rem_reg, saved_rem_next;

    // Request held over the wait cycle, and the result register.
    fbf_pkg::req_t    op_reg;
    fbf_pkg::result_t result_reg, result_next;
    logic             done_reg;

    // Store ports and per-step values.
    logic                       byte_we;
    logic                       len_we;
    logic [fbf_pkg::BYTE_W-1:0] byte_rdata;
    logic [CNT_W-1:0]           len_rdata;
    logic [fbf_pkg::FUNC_W-1:0] func;
    logic [fbf_pkg::BYTE_W-1:0] data;
    logic [fbf_pkg::BYTE_W-1:0] rbyte;
    logic [CNT_W-1:0]           flen;
    logic                       fault;
    logic [LEN_EXT_W-1:0]       flen_ext;
    logic [LEN_EXT_W-1:0]       rem_ext;
    logic [WAIT_EXT_W-1:0]      closed_ext;

    // Byte store: written at the write pointer, read at the read pointer.
    fbf_ram #(
        .WIDTH (fbf_pkg::BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (bwp_reg),
        .wdata (data),
        .raddr (brp_reg),
        .rdata (byte_rdata)
    );

    // Length store: one entry per closed frame.
    fbf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (FRAME_DEPTH)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (lwp_reg),
        .wdata (ofc_reg),
        .raddr (lrp_reg),
        .rdata (len_rdata)
    );

    // Pop and open must wait for the registered store read when they succeed.
    assign stat.needs_read = ((req.func == fbf_pkg::FUNC_POP) && (rem_reg != '0)) ||
                             ((req.func == fbf_pkg::FUNC_OPEN) && (closed_reg != '0));

    // Operation under execution: the live request, or the one held over the wait.
    assign func = cmd.use_latched ? op_reg.func : req.func;
    assign data = cmd.use_latched ? op_reg.data_byte : req.data_byte;

    // Marker register and held request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= '0;
        end
        else if (cfg_we)
        begin
            marker_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= req;
        end
    end

    // Operation decode and next-state computation.
    always_comb
    begin
        bwp_next       = bwp_reg;
        brp_next       = brp_reg;
        ofc_next       = ofc_reg;
        lwp_next       = lwp_reg;
        lrp_next       = lrp_reg;
        closed_next    = closed_reg;
        rem_next       = rem_reg;
        saved_rp_next  = saved_rp_reg;
        saved_rem_next = saved_rem_reg;
        byte_we        = 1'b0;
        len_we         = 1'b0;
        rbyte          = '0;
        flen           = '0;
        fault          = 1'b0;
        if (cmd.commit)
        begin
            case (func)
                fbf_pkg::FUNC_PUSH_FRAMED, fbf_pkg::FUNC_PUSH_RAW:
                begin
                    if ((func == fbf_pkg::FUNC_PUSH_FRAMED) && (data == marker_reg))
                    begin
                        // Marker closes the open frame unless the length ring is full.
                        if (closed_reg >= FC_W'(FRAME_DEPTH))
                        begin
                            fault = 1'b1;
                        end
                        else
                        begin
                            len_we      = 1'b1;
                            lwp_next    = (lwp_reg == FA_W'(FRAME_DEPTH - 1)) ?
                                          '0 : lwp_reg + FA_W'(1);
                            closed_next = closed_reg + FC_W'(1);
                            flen        = ofc_reg;
                            ofc_next    = '0;
                        end
                    end
                    else
                    begin
                        // Store the byte; the byte ring overwrites when it wraps.
                        byte_we  = 1'b1;
                        bwp_next = (bwp_reg == BA_W'(DATA_DEPTH - 1)) ?
                                   '0 : bwp_reg + BA_W'(1);
                        if (ofc_reg < CNT_W'(DATA_DEPTH))
                        begin
                            ofc_next = ofc_reg + CNT_W'(1);
                        end
                    end
                end
                fbf_pkg::FUNC_POP:
                begin
                    if (rem_reg == '0)
                    begin
                        fault = 1'b1;
                    end
                    else
                    begin
                        rbyte    = byte_rdata;
                        brp_next = (brp_reg == BA_W'(DATA_DEPTH - 1)) ?
                                   '0 : brp_reg + BA_W'(1);
                        rem_next = rem_reg - CNT_W'(1);
                    end
                end
                fbf_pkg::FUNC_OPEN:
                begin
                    if (closed_reg == '0)
                    begin
                        fault = 1'b1;
                    end
                    else
                    begin
                        rem_next       = len_rdata;
                        saved_rp_next  = brp_reg;
                        saved_rem_next = len_rdata;
                        lrp_next       = (lrp_reg == FA_W'(FRAME_DEPTH - 1)) ?
                                         '0 : lrp_reg + FA_W'(1);
                        closed_next    = closed_reg - FC_W'(1);
                        flen           = len_rdata;
                    end
                end
                fbf_pkg::FUNC_REOPEN:
                begin
                    brp_next = saved_rp_reg;
                    rem_next = saved_rem_reg;
                end
                default:
                begin
                    fault = 1'b0;
                end
            endcase
        end
    end

    // Result fields, fitted to the field widths.
    assign flen_ext   = LEN_EXT_W'(flen);
    assign rem_ext    = LEN_EXT_W'(rem_next);
    assign closed_ext = WAIT_EXT_W'(closed_next);

    always_comb
    begin
        result_next.read_byte      = rbyte;
        result_next.frame_length   = flen_ext[fbf_pkg::LEN_FLD_W-1:0];
        result_next.bytes_left     = rem_ext[fbf_pkg::LEN_FLD_W-1:0];
        result_next.frames_waiting = closed_ext[fbf_pkg::WAIT_FLD_W-1:0];
        result_next.fault          = fault;
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bwp_reg       <= '0;
            brp_reg       <= '0;
            ofc_reg       <= '0;
            lwp_reg       <= '0;
            lrp_reg       <= '0;
            closed_reg    <= '0;
            rem_reg       <= '0;
            saved_rp_reg  <= '0;
            saved_rem_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            bwp_reg       <= bwp_next;
            brp_reg       <= brp_next;
            ofc_reg       <= ofc_next;
            lwp_reg       <= lwp_next;
            lrp_reg       <= lrp_next;
            closed_reg    <= closed_next;
            rem_reg       <= rem_next;
            saved_rp_reg  <= saved_rp_next;
            saved_rem_reg <= saved_rem_next;
            done_reg      <= cmd.commit;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: sv/framed_byte_fifo_top.sv
// Top level of the framed byte FIFO: controller plus datapath.
// Depends on fbf_pkg, fbf_ctrl, fbf_datapath and fbf_ram.
//
// A request is taken when start is high and busy is low. Pushes, reopen,
// unknown codes and every refused operation finish in the cycle they are
// taken, so they can be issued back to back. A successful pop or open read
// frame waits for the registered read port of the byte store or the length
// store; busy is high while it waits. Each request gives exactly one result,
// shown on result for the single cycle in which done is high, in the cycle
// after the request finishes. The receiver cannot hold results off and must
// take each one as it appears. The user must write the frame marker through
// cfg_we and cfg_wdata only while no request is in flight; the block does not enforce this.
module framed_byte_fifo_top #(
    parameter int DATA_DEPTH  = fbf_pkg::DATA_DEPTH_DEF,
    parameter int FRAME_DEPTH = fbf_pkg::FRAME_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  fbf_pkg::req_t              req,
    input  logic                       cfg_we,
    input  logic [fbf_pkg::BYTE_W-1:0] cfg_wdata,
    output logic                       done,
    output fbf_pkg::result_t           result
);

    fbf_pkg::cmd_t  cmd;
    fbf_pkg::stat_t stat;

    // Sequencing of requests that finish at once and requests that wait for a store read.
    fbf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Rings, counters and result register.
    fbf_datapath #(
        .DATA_DEPTH  (DATA_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

// File: sv/fbf_checker.sv
// Port-level checks for the framed byte FIFO, bound to the top level.
// Depends on fbf_pkg and framed_byte_fifo_top.
module fbf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input fbf_pkg::result_t result
);

    // A taken request shows its result in the next cycle or raises busy.
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("taken request neither finished nor went busy");

    // Busy always drops in the cycle after it rises.
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // The wait cycle is followed by the result of the waiting request.
    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("no result after the wait cycle");

    // No result can be shown in the wait cycle.
    a_no_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result shown during the wait cycle");

    // A refused request never returns a byte.
    a_fault_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.fault) |-> (result.read_byte == '0))
        else $error("refused request returned a byte");

endmodule

bind framed_byte_fifo_top fbf_checker u_fbf_checker (.*);
